### hw/rtl/ansi_sgr_attribute_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// SGR attribute decoder assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ANSI_SGR_ATTRIBUTE_DECODER_TOP_ASSERT_SVH
`define ANSI_SGR_ATTRIBUTE_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SGR_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("sgr assertion failed");

`define SGR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgr assertion failed");

`define SGR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgr assertion failed");

`else

`define SGR_ASSERT_ALWAYS(lbl, expr)
`define SGR_ASSERT_IMPLY(lbl, ante, cons)
`define SGR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/sgr_pkg.sv
// ----------------------------------------------------------------------------
// SGR decoder package
// Types, code constants, palette and colour helpers shared by the decoder.
// ----------------------------------------------------------------------------
package sgr_pkg;

  typedef logic [15:0] code_t;
  typedef logic [23:0] rgb_t;
  typedef logic [7:0]  chan_t;
  typedef logic        reg_idx_t;

  localparam reg_idx_t REG_DEFAULT_FG = 1'b0;
  localparam reg_idx_t REG_DEFAULT_BG = 1'b1;

  localparam rgb_t DEFAULT_FG_RESET = 24'hD8DEE9;
  localparam rgb_t DEFAULT_BG_RESET = 24'h000000;

  localparam code_t SGR_RESET      = 16'd0;
  localparam code_t SGR_BOLD       = 16'd1;
  localparam code_t SGR_REVERSE    = 16'd7;
  localparam code_t SGR_NORMAL     = 16'd22;
  localparam code_t SGR_NO_REVERSE = 16'd27;
  localparam code_t SGR_FG_LO      = 16'd30;
  localparam code_t SGR_FG_HI      = 16'd37;
  localparam code_t SGR_FG_EXT     = 16'd38;
  localparam code_t SGR_FG_DEFAULT = 16'd39;
  localparam code_t SGR_BG_LO      = 16'd40;
  localparam code_t SGR_BG_HI      = 16'd47;
  localparam code_t SGR_BG_EXT     = 16'd48;
  localparam code_t SGR_BG_DEFAULT = 16'd49;
  localparam code_t SGR_FG_BRT_LO  = 16'd90;
  localparam code_t SGR_FG_BRT_HI  = 16'd97;
  localparam code_t SGR_BG_BRT_LO  = 16'd100;
  localparam code_t SGR_BG_BRT_HI  = 16'd107;
  localparam code_t SGR_SEL_RGB    = 16'd2;
  localparam code_t SGR_SEL_INDEX  = 16'd5;

  localparam chan_t CUBE_FIRST  = 8'd16;
  localparam chan_t GRAY_FIRST  = 8'd232;
  localparam chan_t GRAY_BASE   = 8'd8;
  localparam chan_t GRAY_STEP   = 8'd10;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SELECT,
    PH_INDEX,
    PH_RGB
  } phase_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RESET,
    OP_BOLD_SET,
    OP_BOLD_CLR,
    OP_REV_SET,
    OP_REV_CLR,
    OP_FG_PAL,
    OP_FG_DEF,
    OP_BG_PAL,
    OP_BG_DEF
  } plain_op_t;

  typedef struct packed {
    plain_op_t  op;
    logic [3:0] pal;
  } plain_t;

  typedef struct packed {
    plain_t first;
    plain_t second;
    logic   ext_valid;
    logic   ext_bg;
    rgb_t   ext_color;
    logic   pending;
  } cmd_t;

  typedef struct packed {
    rgb_t fg;
    rgb_t bg;
    logic bg_explicit;
    logic bold;
    logic reverse;
  } attr_t;

  function automatic rgb_t palette16(input logic [3:0] idx);
    rgb_t c;
    unique case (idx)
      4'd0:    c = 24'h15161E;
      4'd1:    c = 24'hF7768E;
      4'd2:    c = 24'h9ECE6A;
      4'd3:    c = 24'hE0AF68;
      4'd4:    c = 24'h7AA2F7;
      4'd5:    c = 24'hBB9AF7;
      4'd6:    c = 24'h7DCFFF;
      4'd7:    c = 24'hC0CAF5;
      4'd8:    c = 24'h414868;
      4'd9:    c = 24'hFF899D;
      4'd10:   c = 24'hB9F27C;
      4'd11:   c = 24'hF4C97A;
      4'd12:   c = 24'h8DB0FF;
      4'd13:   c = 24'hC7A9FF;
      4'd14:   c = 24'h9BE8FF;
      default: c = 24'hF4F7FF;
    endcase
    return c;
  endfunction

  function automatic chan_t cube_level(input logic [2:0] lvl);
    chan_t v;
    unique case (lvl)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd95;
      3'd2:    v = 8'd135;
      3'd3:    v = 8'd175;
      3'd4:    v = 8'd215;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  // xterm-256: palette, 6x6x6 cube, gray ramp
  function automatic rgb_t color256(input chan_t idx);
    chan_t       v;
    logic [17:0] p6;
    logic [5:0]  q6;
    logic [13:0] pr;
    logic [2:0]  r;
    logic [2:0]  g;
    logic [2:0]  b;
    chan_t       lin;
    chan_t       gray;
    rgb_t        c;
    v    = idx - CUBE_FIRST;
    p6   = 18'(v) * 18'd171;          // v / 6 for v < 216
    q6   = p6[15:10];
    b    = 3'(v - 8'(q6) * 8'd6);
    pr   = 14'(q6) * 14'd43;          // q6 / 6 for q6 < 36
    r    = pr[10:8];
    g    = 3'(q6 - 6'(r) * 6'd6);
    lin  = idx - GRAY_FIRST;
    gray = GRAY_BASE + lin * GRAY_STEP;
    if (idx < CUBE_FIRST) begin
      c = palette16(idx[3:0]);
    end else if (idx < GRAY_FIRST) begin
      c = {cube_level(r), cube_level(g), cube_level(b)};
    end else begin
      c = {gray, gray, gray};
    end
    return c;
  endfunction

  function automatic plain_t classify(input code_t c);
    plain_t p;
    p.op  = OP_NONE;
    p.pal = 4'd0;
    priority if (c == SGR_RESET) begin
      p.op = OP_RESET;
    end else if (c == SGR_BOLD) begin
      p.op = OP_BOLD_SET;
    end else if (c == SGR_NORMAL) begin
      p.op = OP_BOLD_CLR;
    end else if (c == SGR_REVERSE) begin
      p.op = OP_REV_SET;
    end else if (c == SGR_NO_REVERSE) begin
      p.op = OP_REV_CLR;
    end else if (c >= SGR_FG_LO && c <= SGR_FG_HI) begin
      p.op  = OP_FG_PAL;
      p.pal = {1'b0, 3'(c - SGR_FG_LO)};
    end else if (c >= SGR_FG_BRT_LO && c <= SGR_FG_BRT_HI) begin
      p.op  = OP_FG_PAL;
      p.pal = {1'b1, 3'(c - SGR_FG_BRT_LO)};
    end else if (c == SGR_FG_DEFAULT) begin
      p.op = OP_FG_DEF;
    end else if (c >= SGR_BG_LO && c <= SGR_BG_HI) begin
      p.op  = OP_BG_PAL;
      p.pal = {1'b0, 3'(c - SGR_BG_LO)};
    end else if (c >= SGR_BG_BRT_LO && c <= SGR_BG_BRT_HI) begin
      p.op  = OP_BG_PAL;
      p.pal = {1'b1, 3'(c - SGR_BG_BRT_LO)};
    end else if (c == SGR_BG_DEFAULT) begin
      p.op = OP_BG_DEF;
    end else begin
      p.op = OP_NONE;
    end
    return p;
  endfunction

endpackage

### hw/rtl/sgr_code_if.sv
// ----------------------------------------------------------------------------
// SGR code channel
// One SGR parameter per item, with an end-of-sequence flag.
// ----------------------------------------------------------------------------
interface sgr_code_if;
  import sgr_pkg::*;

  logic  valid;
  logic  ready;
  code_t code;
  logic  last;

  modport source (output valid, output code, output last, input ready);
  modport sink   (input valid, input code, input last, output ready);
endinterface

### hw/rtl/sgr_attr_if.sv
// ----------------------------------------------------------------------------
// SGR attribute channel
// Current text attributes, one item per accepted code.
// ----------------------------------------------------------------------------
interface sgr_attr_if;
  import sgr_pkg::*;

  logic valid;
  logic ready;
  rgb_t fg_color;
  rgb_t bg_color;
  logic bg_explicit;
  logic bold_on;
  logic reverse_on;
  logic pending;

  modport source (output valid, output fg_color, output bg_color, output bg_explicit,
                  output bold_on, output reverse_on, output pending, input ready);
  modport sink   (input valid, input fg_color, input bg_color, input bg_explicit,
                  input bold_on, input reverse_on, input pending, output ready);
endinterface

### hw/rtl/sgr_cfg_if.sv
// ----------------------------------------------------------------------------
// SGR configuration write channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface sgr_cfg_if;
  import sgr_pkg::*;

  logic     valid;
  logic     ready;
  reg_idx_t index;
  rgb_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/sgr_front.sv
// ----------------------------------------------------------------------------
// SGR front end
// Parses the code stream (38/48 extended colours, held RGB components) and
// issues one command per item.
// ----------------------------------------------------------------------------
`include "ansi_sgr_attribute_decoder_top_assert.svh"

module sgr_front (
  input  logic          clk,
  input  logic          rst,
  sgr_code_if.sink      codes,
  output logic          push_valid,
  input  logic          push_ready,
  output sgr_pkg::cmd_t push_cmd
);
  import sgr_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic       ext_bg;
  logic       ext_bg_next;
  logic [1:0] held_count;
  logic [1:0] held_count_next;
  code_t      held0;
  code_t      held0_next;
  chan_t      held1;
  chan_t      held1_next;
  chan_t      held2;
  chan_t      held2_next;
  logic       accept;
  logic       is_ext;
  cmd_t       cmd;

  assign codes.ready = push_ready;
  assign push_valid  = codes.valid;
  assign accept      = codes.valid && push_ready;
  assign is_ext      = (codes.code == SGR_FG_EXT) || (codes.code == SGR_BG_EXT);
  assign push_cmd    = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      ext_bg     <= 1'b0;
      held_count <= 2'd0;
    end else if (accept) begin
      phase      <= phase_next;
      ext_bg     <= ext_bg_next;
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held0 <= held0_next;
      held1 <= held1_next;
      held2 <= held2_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    ext_bg_next     = ext_bg;
    held_count_next = held_count;
    held0_next      = held0;
    held1_next      = held1;
    held2_next      = held2;
    cmd.first       = '{op: OP_NONE, pal: 4'd0};
    cmd.second      = '{op: OP_NONE, pal: 4'd0};
    cmd.ext_valid   = 1'b0;
    cmd.ext_bg      = ext_bg;
    cmd.ext_color   = '0;
    unique case (phase)
      PH_IDLE, PH_SELECT: begin
        phase_next = PH_IDLE;
        if (phase == PH_SELECT && codes.code == SGR_SEL_INDEX && !codes.last) begin
          phase_next = PH_INDEX;
        end else if (phase == PH_SELECT && codes.code == SGR_SEL_RGB && !codes.last) begin
          phase_next      = PH_RGB;
          held_count_next = 2'd0;
        end else if (phase == PH_SELECT && (codes.code == SGR_SEL_INDEX ||
                                            codes.code == SGR_SEL_RGB)) begin
          phase_next = PH_IDLE;
        end else if (is_ext) begin
          if (!codes.last) begin
            phase_next  = PH_SELECT;
            ext_bg_next = (codes.code == SGR_BG_EXT);
          end
        end else begin
          cmd.first = classify(codes.code);
        end
      end
      PH_INDEX: begin
        phase_next    = PH_IDLE;
        cmd.ext_valid = 1'b1;
        cmd.ext_color = color256(codes.code[7:0]);
      end
      PH_RGB: begin
        unique case (held_count)
          2'd0: begin
            held0_next = codes.code;
            if (codes.last) begin
              cmd.first  = classify(codes.code);
              phase_next = PH_IDLE;
            end else begin
              held_count_next = 2'd1;
            end
          end
          2'd1: begin
            held1_next = codes.code[7:0];
            if (codes.last) begin
              cmd.first       = classify(held0);
              cmd.second      = classify(codes.code);
              phase_next      = PH_IDLE;
              held_count_next = 2'd0;
            end else begin
              held_count_next = 2'd2;
            end
          end
          2'd2: begin
            held2_next = codes.code[7:0];
            if (codes.last || held0 != '0) begin
              cmd.ext_valid   = 1'b1;
              cmd.ext_color   = {held0[7:0], held1, codes.code[7:0]};
              phase_next      = PH_IDLE;
              held_count_next = 2'd0;
            end else begin
              held_count_next = 2'd3;
            end
          end
          default: begin
            // colour-space id form: 2;0;r;g;b
            cmd.ext_valid   = 1'b1;
            cmd.ext_color   = {held1, held2, codes.code[7:0]};
            phase_next      = PH_IDLE;
            held_count_next = 2'd0;
          end
        endcase
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    cmd.pending = (phase_next != PH_IDLE);
  end

  `SGR_ASSERT_IMPLY(a_held_only_in_rgb, held_count != 2'd0, phase == PH_RGB)

endmodule

### hw/rtl/sgr_queue.sv
// ----------------------------------------------------------------------------
// SGR command queue
// Short register FIFO between the front end and the attribute back end.
// ----------------------------------------------------------------------------
`include "ansi_sgr_attribute_decoder_top_assert.svh"

module sgr_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  sgr_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output sgr_pkg::cmd_t pop_cmd
);
  import sgr_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  `SGR_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH))
  `SGR_ASSERT_NEXT(a_count_rise, push && !pop, count == $past(count) + 1'b1)
  `SGR_ASSERT_NEXT(a_empty_head, push && count == '0, pop_cmd == $past(push_cmd))

endmodule

### hw/rtl/sgr_back.sv
// ----------------------------------------------------------------------------
// SGR back end
// Applies commands to the attribute registers and holds the result item.
// ----------------------------------------------------------------------------
module sgr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  sgr_pkg::cmd_t pop_cmd,
  sgr_cfg_if.sink       cfg,
  sgr_attr_if.source    attrs
);
  import sgr_pkg::*;

  rgb_t  default_fg;
  rgb_t  default_bg;
  attr_t attr;
  attr_t attr_next;
  logic  pending;
  logic  out_valid;
  logic  take;

  function automatic attr_t apply_plain(input attr_t a, input plain_t p,
                                        input rgb_t dfg, input rgb_t dbg);
    attr_t r;
    r = a;
    unique case (p.op)
      OP_RESET: begin
        r.fg          = dfg;
        r.bg          = dbg;
        r.bg_explicit = 1'b0;
        r.bold        = 1'b0;
        r.reverse     = 1'b0;
      end
      OP_BOLD_SET: r.bold    = 1'b1;
      OP_BOLD_CLR: r.bold    = 1'b0;
      OP_REV_SET:  r.reverse = 1'b1;
      OP_REV_CLR:  r.reverse = 1'b0;
      OP_FG_PAL:   r.fg      = palette16(p.pal);
      OP_FG_DEF:   r.fg      = dfg;
      OP_BG_PAL: begin
        r.bg          = palette16(p.pal);
        r.bg_explicit = 1'b1;
      end
      OP_BG_DEF: begin
        r.bg          = dbg;
        r.bg_explicit = 1'b0;
      end
      default: r = a;
    endcase
    return r;
  endfunction

  assign cfg.ready = 1'b1;
  assign pop_ready = !out_valid || attrs.ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    attr_next = apply_plain(attr, pop_cmd.first, default_fg, default_bg);
    attr_next = apply_plain(attr_next, pop_cmd.second, default_fg, default_bg);
    if (pop_cmd.ext_valid) begin
      if (pop_cmd.ext_bg) begin
        attr_next.bg          = pop_cmd.ext_color;
        attr_next.bg_explicit = 1'b1;
      end else begin
        attr_next.fg = pop_cmd.ext_color;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_fg <= DEFAULT_FG_RESET;
      default_bg <= DEFAULT_BG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DEFAULT_FG: default_fg <= cfg.data;
        REG_DEFAULT_BG: default_bg <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr      <= '{fg: DEFAULT_FG_RESET, bg: DEFAULT_BG_RESET, bg_explicit: 1'b0,
                     bold: 1'b0, reverse: 1'b0};
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else if (take) begin
      attr      <= attr_next;
      pending   <= pop_cmd.pending;
      out_valid <= 1'b1;
    end else if (attrs.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign attrs.valid       = out_valid;
  assign attrs.fg_color    = attr.fg;
  assign attrs.bg_color    = attr.bg;
  assign attrs.bg_explicit = attr.bg_explicit;
  assign attrs.bold_on     = attr.bold;
  assign attrs.reverse_on  = attr.reverse;
  assign attrs.pending     = pending;

endmodule

### hw/rtl/ansi_sgr_attribute_decoder_top.sv
// ----------------------------------------------------------------------------
// SGR attribute decoder, top level
// Channel  Dir  Payload
// codes    in   code[15:0], last
// attrs    out  fg_color, bg_color, bg_explicit, bold_on, reverse_on, pending
// cfg      in   index (0 default fg, 1 default bg), data[23:0]
//
// One item per cycle sustained while attrs.ready is high; each code's command is written
// into the queue by the front end, then into the output register by the back end.
// Front end parse state and back end attribute registers update on each accepted item.
// rst is synchronous, restores the default colours and clears the control state.
// A stalled attrs channel fills the queue, after which codes.ready drops.
// ----------------------------------------------------------------------------
module ansi_sgr_attribute_decoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  sgr_code_if.sink   codes,
  sgr_attr_if.source attrs,
  sgr_cfg_if.sink    cfg
);
  import sgr_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  sgr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .codes      (codes),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  sgr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  sgr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .cfg       (cfg),
    .attrs     (attrs)
  );

endmodule
